@@ rtl/core/hsd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsd_pkg
// shared widths, fixed-point constants and elaboration-time table functions
// for the haversine step distance block
// ----------------------------------------------------------------------------
package hsd_pkg;

  localparam int unsigned CORDIC_ITER_DEF = 32;
  localparam int unsigned QW = 36;

  localparam logic signed [QW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [QW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic [30:0]          ONE_Q30     = 31'd1073741824;

  localparam logic signed [33:0] HALF_TURN_DEG7 = 34'sd1800000000;
  localparam logic signed [33:0] FULL_TURN_DEG7 = 34'sd3600000000;
  localparam logic [31:0]        DIV_FULL       = 32'd3600000000;
  localparam logic [31:0]        DIV_HALF       = 32'd1800000000;

  localparam logic [22:0] EARTH_RADIUS_RESET = 23'd6371000;
  localparam logic [24:0] DIST_MAX           = 25'd33554431;

  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_ctrl_t;

  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] isqrt64(logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
    v = v_in;
    res = '0;
    bt = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] atan_q30(int i);
    logic signed [63:0] sum;
    logic [63:0] term;
    sum = '0;
    term = '0;
    if (i == 0) begin
      return 64'(PI_Q30 >>> 2);
    end
    for (int k = 0; k < 31; k++) begin
      if (i * (2 * k + 1) <= 60) begin
        term = udiv64(64'd1 << (60 - i * (2 * k + 1)), 64'(2 * k + 1));
        if (k % 2 == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
    end
    return 64'((sum + 64'sd536870912) >>> 30);
  endfunction

  function automatic logic [63:0] kinv_q30(int n);
    logic [63:0] p;
    logic [63:0] g;
    p = 64'd1 << 60;
    for (int i = 0; i < n; i++) begin
      if (2 * i < 63) begin
        p = p + (p >> (2 * i));
      end
    end
    g = isqrt64(p);
    return udiv64((64'd1 << 60) + (g >> 1), g);
  endfunction

  // pi over the turn divisors, scaled by 2^61, for the angle conversion estimate
  localparam logic [31:0] RECIP_HALF = 32'(udiv64(64'(PI_Q30) << 31, 64'(DIV_HALF)));
  localparam logic [31:0] RECIP_FULL = 32'(udiv64(64'(PI_Q30) << 31, 64'(DIV_FULL)));

endpackage

@@ rtl/core/haversine_step_distance.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haversine_step_distance
// great-circle distance between successive positions, sequenced over one
// shared multiplier, one 64-bit subtractor and one cordic unit
// ----------------------------------------------------------------------------
// sequence: four angle conversions through S_CMUL, S_CREC and S_CCHK,
//   five cordic runs and two 32-step roots
// first position: absorbed, no word out
// one position at a time: input stalled while in work
// reset: no previous position, radius 6371000 m, output empty
// ----------------------------------------------------------------------------
module haversine_step_distance import hsd_pkg::*; #(
  parameter int unsigned CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [30:0] latitude_i,
  input  logic signed [31:0] longitude_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [24:0]        distance_m_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [22:0]        cfg_data_i
);

  localparam logic signed [QW-1:0] KINV = QW'(kinv_q30(CORDIC_ITERATIONS));

  typedef enum logic [3:0] {
    S_IDLE, S_CMUL, S_CREC, S_CCHK, S_CSTART, S_CWAIT, S_M1, S_M2, S_M3, S_M4,
    S_SQINIT, S_SQ1, S_SQ2, S_ASTART, S_AWAIT, S_FMUL
  } state_e;

  state_e               state_q;
  logic [22:0]          radius_q;
  logic                 have_prev_q;
  logic signed [30:0]   last_lat_q;
  logic signed [31:0]   last_lon_q;
  logic signed [31:0]   dlat_q, dlon_q;
  logic signed [30:0]   lat_a_q, lat_b_q;
  logic [1:0]           idx_q;
  logic [5:0]           cnt_q;
  logic [63:0]          rem_q, res_q, bit_q;
  logic signed [32:0]   s1_q, s2_q, cl1_q, cl2_q;
  logic signed [QW-1:0] m1_q, m2_q, m3_q;
  logic [30:0]          a_q, sy_q, sx_q;
  logic [31:0]          ang_q;
  logic [24:0]          dist_q;
  logic                 out_valid_q;

  logic signed [33:0]   dlon_raw, dlon_wrap;
  logic signed [32:0]   conv_d, conv_mag;
  logic                 conv_neg;
  logic [31:0]          conv_div, conv_rcp;
  logic signed [32:0]   mul_a, mul_b;
  logic signed [65:0]   prod, prod_rnd, prod_est;
  logic signed [QW-1:0] mulq_res;
  logic [63:0]          sub_b, res_sq;
  logic [64:0]          diff;
  logic                 ge;
  logic signed [36:0]   a_sum;
  logic signed [QW-1:0] theta;
  logic signed [QW-1:0] cx_o, cy_o, cz_o;
  logic signed [QW-1:0] cx_i, cy_i, cz_i;
  logic signed [QW:0]   ang_full;
  logic                 cordic_busy;
  cordic_ctrl_t         cctrl;

  always_comb begin
    dlon_raw = {{2{last_lon_q[31]}}, last_lon_q} - {{2{longitude_i[31]}}, longitude_i};
    dlon_wrap = dlon_raw;
    if (dlon_raw > HALF_TURN_DEG7) begin
      dlon_wrap = dlon_raw - FULL_TURN_DEG7;
    end else if (dlon_raw < -HALF_TURN_DEG7) begin
      dlon_wrap = dlon_raw + FULL_TURN_DEG7;
    end

    case (idx_q)
      2'd0:    conv_d = 33'(dlat_q);
      2'd1:    conv_d = 33'(dlon_q);
      2'd2:    conv_d = 33'(lat_a_q);
      default: conv_d = 33'(lat_b_q);
    endcase
    conv_neg = conv_d[32];
    conv_mag = conv_neg ? -conv_d : conv_d;
    conv_div = idx_q[1] ? DIV_HALF : DIV_FULL;
    conv_rcp = idx_q[1] ? RECIP_HALF : RECIP_FULL;

    case (state_q)
      S_CMUL: begin
        mul_a = {2'b00, conv_mag[30:0]};
        mul_b = 33'(PI_Q30);
      end
      S_CREC: begin
        mul_a = {2'b00, conv_mag[30:0]};
        mul_b = {1'b0, conv_rcp};
      end
      S_CCHK: begin
        mul_a = {1'b0, res_q[31:0]};
        mul_b = {1'b0, conv_div};
      end
      S_M1: begin
        mul_a = s1_q;
        mul_b = s1_q;
      end
      S_M2: begin
        mul_a = cl1_q;
        mul_b = cl2_q;
      end
      S_M3: begin
        mul_a = s2_q;
        mul_b = s2_q;
      end
      S_M4: begin
        mul_a = m2_q[32:0];
        mul_b = m3_q[32:0];
      end
      S_FMUL: begin
        mul_a = {10'd0, radius_q};
        mul_b = {1'b0, ang_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod     = 66'(mul_a) * 66'(mul_b);
    prod_rnd = prod + 66'sd536870912;
    // rounded estimate plus one, at most one above the true quotient
    prod_est = prod + 66'sd3221225472;
    mulq_res = QW'(prod_rnd >>> 30);

    sub_b  = (state_q == S_CCHK) ? prod[63:0] : (res_q + bit_q);
    diff   = {1'b0, rem_q} - {1'b0, sub_b};
    ge     = ~diff[64];
    res_sq = ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);

    a_sum = 37'(m1_q) + 37'(mulq_res);
    theta = conv_neg ? -QW'(res_q[32:0]) : QW'(res_q[32:0]);
    ang_full = {cz_o, 1'b0};

    cctrl.start     = (state_q == S_CSTART) || (state_q == S_ASTART);
    cctrl.vectoring = (state_q == S_ASTART);
    cx_i = (state_q == S_ASTART) ? QW'(sx_q) : KINV;
    cy_i = (state_q == S_ASTART) ? QW'(sy_q) : '0;
    cz_i = (state_q == S_ASTART) ? '0 : theta;
  end

  hsd_cordic #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (cctrl),
    .x_i    (cx_i),
    .y_i    (cy_i),
    .z_i    (cz_i),
    .x_o    (cx_o),
    .y_o    (cy_o),
    .z_o    (cz_o),
    .busy_o (cordic_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      radius_q    <= EARTH_RADIUS_RESET;
      have_prev_q <= 1'b0;
      last_lat_q  <= '0;
      last_lon_q  <= '0;
      dlat_q      <= '0;
      dlon_q      <= '0;
      lat_a_q     <= '0;
      lat_b_q     <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      rem_q       <= '0;
      res_q       <= '0;
      bit_q       <= '0;
      s1_q        <= '0;
      s2_q        <= '0;
      cl1_q       <= '0;
      cl2_q       <= '0;
      m1_q        <= '0;
      m2_q        <= '0;
      m3_q        <= '0;
      a_q         <= '0;
      sy_q        <= '0;
      sx_q        <= '0;
      ang_q       <= '0;
      dist_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        radius_q <= cfg_data_i;
      end
      if ((state_q == S_FMUL) && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            have_prev_q <= 1'b1;
            last_lat_q  <= latitude_i;
            last_lon_q  <= longitude_i;
            dlat_q      <= {last_lat_q[30], last_lat_q} - {latitude_i[30], latitude_i};
            dlon_q      <= 32'(dlon_wrap);
            lat_a_q     <= latitude_i;
            lat_b_q     <= last_lat_q;
            idx_q       <= '0;
            if (have_prev_q) begin
              state_q <= S_CMUL;
            end
          end
        end
        S_CMUL: begin
          rem_q   <= 64'(prod) + {33'd0, conv_div[31:1]};
          state_q <= S_CREC;
        end
        S_CREC: begin
          res_q   <= 64'(prod_est >>> 31);
          state_q <= S_CCHK;
        end
        S_CCHK: begin
          if (!ge) begin
            res_q <= res_q - 1'b1;
          end
          state_q <= S_CSTART;
        end
        S_CSTART: begin
          state_q <= S_CWAIT;
        end
        S_CWAIT: begin
          if (!cordic_busy) begin
            case (idx_q)
              2'd0:    s1_q  <= 33'(cy_o);
              2'd1:    s2_q  <= 33'(cy_o);
              2'd2:    cl1_q <= 33'(cx_o);
              default: cl2_q <= 33'(cx_o);
            endcase
            idx_q <= idx_q + 1'b1;
            state_q <= (idx_q == 2'd3) ? S_M1 : S_CMUL;
          end
        end
        S_M1: begin
          m1_q    <= mulq_res;
          state_q <= S_M2;
        end
        S_M2: begin
          m2_q    <= mulq_res;
          state_q <= S_M3;
        end
        S_M3: begin
          m3_q    <= mulq_res;
          state_q <= S_M4;
        end
        S_M4: begin
          if (a_sum[36]) begin
            a_q <= '0;
          end else if (a_sum > 37'(ONE_Q30)) begin
            a_q <= ONE_Q30;
          end else begin
            a_q <= a_sum[30:0];
          end
          state_q <= S_SQINIT;
        end
        S_SQINIT: begin
          rem_q   <= {3'd0, a_q, 30'd0};
          res_q   <= '0;
          bit_q   <= 64'h4000_0000_0000_0000;
          cnt_q   <= '0;
          state_q <= S_SQ1;
        end
        S_SQ1: begin
          if (cnt_q == 6'd31) begin
            sy_q    <= res_sq[30:0];
            rem_q   <= {3'd0, ONE_Q30 - a_q, 30'd0};
            res_q   <= '0;
            bit_q   <= 64'h4000_0000_0000_0000;
            cnt_q   <= '0;
            state_q <= S_SQ2;
          end else begin
            if (ge) begin
              rem_q <= diff[63:0];
            end
            res_q <= res_sq;
            bit_q <= bit_q >> 2;
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_SQ2: begin
          if (ge) begin
            rem_q <= diff[63:0];
          end
          res_q <= res_sq;
          bit_q <= bit_q >> 2;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 6'd31) begin
            sx_q    <= res_sq[30:0];
            state_q <= S_ASTART;
          end
        end
        S_ASTART: begin
          state_q <= S_AWAIT;
        end
        S_AWAIT: begin
          if (!cordic_busy) begin
            ang_q   <= ang_full[QW] ? '0 : ang_full[31:0];
            state_q <= S_FMUL;
          end
        end
        S_FMUL: begin
          // hold until the previous word has left
          if (!out_valid_q || !out_stall_i) begin
            dist_q  <= (|prod_rnd[65:55]) ? DIST_MAX : prod_rnd[54:30];
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign distance_m_o = dist_q;
  assign cfg_ready_o  = 1'b1;

endmodule

@@ rtl/core/hsd_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsd_cordic
// shared cordic unit, rotation mode with half-turn reduction for sine and
// cosine, vectoring mode for atan2, one micro-rotation per cycle
// ----------------------------------------------------------------------------
module hsd_cordic import hsd_pkg::*; #(
  parameter int unsigned CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cordic_ctrl_t           ctrl_i,
  input  logic signed [QW-1:0]   x_i,
  input  logic signed [QW-1:0]   y_i,
  input  logic signed [QW-1:0]   z_i,
  output logic signed [QW-1:0]   x_o,
  output logic signed [QW-1:0]   y_o,
  output logic signed [QW-1:0]   z_o,
  output logic                   busy_o
);

  localparam int unsigned CW = $clog2(CORDIC_ITERATIONS);

  logic signed [QW-1:0] atan_tab [CORDIC_ITERATIONS];

  for (genvar gi = 0; gi < CORDIC_ITERATIONS; gi++) begin : g_atan
    assign atan_tab[gi] = QW'(atan_q30(gi));
  end

  logic [CW-1:0]        cnt_q;
  logic                 busy_q, vec_q, neg_q;
  logic signed [QW-1:0] x_q, y_q, z_q;
  logic signed [QW-1:0] dx, dy, z_red;
  logic                 dir, neg_red;

  always_comb begin
    dx = y_q >>> cnt_q;
    dy = x_q >>> cnt_q;
    dir = vec_q ? y_q[QW-1] : ~z_q[QW-1];
    z_red = z_i;
    neg_red = 1'b0;
    if (!ctrl_i.vectoring && (z_i > HALF_PI_Q30)) begin
      z_red = z_i - PI_Q30;
      neg_red = 1'b1;
    end else if (!ctrl_i.vectoring && (z_i < -HALF_PI_Q30)) begin
      z_red = z_i + PI_Q30;
      neg_red = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      vec_q  <= 1'b0;
      neg_q  <= 1'b0;
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
    end else if (ctrl_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      vec_q  <= ctrl_i.vectoring;
      neg_q  <= neg_red;
      x_q    <= x_i;
      y_q    <= y_i;
      z_q    <= z_red;
    end else if (busy_q) begin
      if (dir) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - atan_tab[cnt_q];
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + atan_tab[cnt_q];
      end
      if (cnt_q == CW'(CORDIC_ITERATIONS - 1)) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  assign x_o    = neg_q ? -x_q : x_q;
  assign y_o    = neg_q ? -y_q : y_q;
  assign z_o    = z_q;
  assign busy_o = busy_q;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the haversine step distance block: every accepted position is fed to
// a fixed-point distance predictor, each distance word out of the block is
// compared with the oldest predicted one, under several radius settings and
// under sender gaps, receiver stalls and a long output hold-off
// ----------------------------------------------------------------------------
module tb import hsd_pkg::*;;

  localparam int unsigned NITER    = 32;
  localparam int          SETTLE   = 400;
  localparam longint      PI_L     = 64'sd3373259426;
  localparam longint      HPI_L    = 64'sd1686629713;
  localparam longint      ONE_L    = 64'sd1073741824;
  localparam longint      HALF_T   = 64'sd1800000000;
  localparam longint      FULL_T   = 64'sd3600000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [30:0] latitude_i = '0;
  logic signed [31:0] longitude_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [24:0]        distance_m_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [22:0]        cfg_data_i = '0;

  haversine_step_distance #(.CORDIC_ITERATIONS(NITER)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .latitude_i(latitude_i), .longitude_i(longitude_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .distance_m_o(distance_m_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  // predictor state
  logic [22:0]        radius_m = EARTH_RADIUS_RESET;
  bit                 have_prev = 1'b0;
  logic signed [30:0] prev_lat = '0;
  logic signed [31:0] prev_lon = '0;
  longint             kinv;

  logic [24:0] distance_q[$];
  int          errors = 0;
  int          words_in = 0;
  int          words_out = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_cycles = 0;
  logic signed [30:0] sent_lat = '0;
  logic signed [31:0] sent_lon = '0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint asr_floor(longint v, int s);
    if (s >= 63) return (v < 0) ? -64'sd1 : 64'sd0;
    return v >>> s;
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    return asr_floor(a * b + (64'sd1 <<< 29), 30);
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic longint arctan_step(int i);
    longint sum, term;
    sum = 0;
    if (i == 0) return PI_L >>> 2;
    for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
      term = longint'((64'd1 << (60 - i * (2 * k + 1))) / (2 * k + 1));
      sum = (k % 2 == 1) ? sum - term : sum + term;
    end
    return (sum + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint gain_inv();
    longint unsigned p, g;
    p = 64'd1 << 60;
    for (int i = 0; i < NITER; i++)
      if (2 * i < 63) p = p + (p >> (2 * i));
    g = root64(p);
    return longint'(((64'd1 << 60) + g / 2) / g);
  endfunction

  function automatic longint deg7_to_q30(longint d, longint unsigned dv);
    longint unsigned mag;
    longint q;
    mag = (d < 0) ? longint'(-d) : d;
    q = longint'((mag * 64'd3373259426 + dv / 2) / dv);
    return (d < 0) ? -q : q;
  endfunction

  task automatic sin_cos(input longint theta, output longint s, output longint c);
    longint x, y, z, dx, dy, t;
    bit neg;
    x = kinv; y = 0; z = theta; neg = 0;
    if (z > HPI_L) begin
      z = z - PI_L; neg = 1;
    end else if (z < -HPI_L) begin
      z = z + PI_L; neg = 1;
    end
    for (int i = 0; i < NITER; i++) begin
      dx = asr_floor(y, i); dy = asr_floor(x, i); t = arctan_step(i);
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - t;
      end else begin
        x = x + dx; y = y - dy; z = z + t;
      end
    end
    s = neg ? -y : y;
    c = neg ? -x : x;
  endtask

  function automatic longint arctan2(longint y, longint x);
    longint z, dx, dy, t;
    z = 0;
    for (int i = 0; i < NITER; i++) begin
      dx = asr_floor(y, i); dy = asr_floor(x, i); t = arctan_step(i);
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + t;
      end else begin
        x = x - dx; y = y + dy; z = z - t;
      end
    end
    return z;
  endfunction

  task automatic predict_distance(input logic signed [30:0] lat_f,
                                  input logic signed [31:0] lon_f);
    longint lat, lon, plat, dlat, dlon, s1, s2, c1, c2, dummy, hav, sy, sx, ang;
    longint unsigned d;
    lat = lat_f; lon = lon_f; plat = prev_lat;
    if (have_prev) begin
      dlat = plat - lat;
      dlon = longint'(prev_lon) - lon;
      if (dlon > HALF_T) dlon = dlon - FULL_T;
      else if (dlon < -HALF_T) dlon = dlon + FULL_T;
      sin_cos(deg7_to_q30(dlat, FULL_T), s1, dummy);
      sin_cos(deg7_to_q30(dlon, FULL_T), s2, dummy);
      sin_cos(deg7_to_q30(lat, HALF_T), dummy, c1);
      sin_cos(deg7_to_q30(plat, HALF_T), dummy, c2);
      hav = mul_q30(s1, s1) + mul_q30(mul_q30(c1, c2), mul_q30(s2, s2));
      if (hav < 0) hav = 0;
      if (hav > ONE_L) hav = ONE_L;
      sy = longint'(root64(longint'(hav) << 30));
      sx = longint'(root64(longint'(ONE_L - hav) << 30));
      ang = 2 * arctan2(sy, sx);
      if (ang < 0) ang = 0;
      d = (longint'(radius_m) * ang + (64'd1 << 29)) >> 30;
      distance_q.push_back((d > 64'd33554431) ? 25'h1ffffff : d[24:0]);
    end
    have_prev = 1'b1;
    prev_lat = lat_f;
    prev_lon = lon_f;
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send_position(input logic signed [30:0] lat, input logic signed [31:0] lon);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
      repeat ($urandom_range(12, 1)) @(posedge clk_i);
    @(posedge clk_i);
    in_valid_i <= 1'b1;
    latitude_i <= lat;
    longitude_i <= lon;
    do @(posedge clk_i); while (in_stall_o);
    predict_distance(lat, lon);
    in_valid_i <= 1'b0;
    sent_lat = lat;
    sent_lon = lon;
    words_in++;
  endtask

  task automatic wait_idle();
    wait (distance_q.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_radius(input logic [22:0] r);
    wait_idle();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= r;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    radius_m = r;
  endtask

  task automatic send_random();
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      lat = 31'(longint'($urandom_range(1800000000)) - 900000000);
      lon = 32'(longint'($urandom_range(32'd3600000000)) - 1800000000);
    end else if (pick < 85) begin
      lat = sent_lat + 31'(longint'($urandom_range(40000)) - 20000);
      lon = sent_lon + 32'(longint'($urandom_range(40000)) - 20000);
    end else begin
      lat = 31'($urandom);
      lon = $urandom;
    end
    send_position(lat, lon);
  endtask

  task automatic test_directed();
    send_position(0, 0);
    send_position(0, 0);
    send_position(0, 32'sd1800000000);
    send_position(0, -32'sd1800000000);
    send_position(0, 32'sd1799999999);
    send_position(0, -32'sd1799999999);
    send_position(31'sd900000000, 0);
    send_position(-31'sd900000000, 32'sd1234567);
    send_position(31'sd900000000, -32'sd7654321);
    send_position(31'sh3fffffff, 32'sh7fffffff);
    send_position(31'sh40000000, 32'sh80000000);
    send_position(31'sh3fffffff, 32'sh80000000);
    send_position(31'sh40000000, 32'sh7fffffff);
    send_position(31'sd10, 32'sd10);
    send_position(31'sd11, 32'sd10);
    send_position(31'sd455000000, 32'sd57000000);
    send_position(-31'sd338000000, 32'sd1512000000);
    send_position(-31'sd1, -32'sd1);
    send_position(31'sd1, 32'sd1);
  endtask

  task automatic test_radius_settings();
    logic [22:0] radii[6];
    radii = '{23'd6300000, 23'd6400000, 23'd0, 23'h7fffff, 23'd1, EARTH_RADIUS_RESET};
    foreach (radii[j]) begin
      write_radius(radii[j]);
      send_position(0, 0);
      send_position(0, 32'sd1800000000);
      send_position(31'sd900000000, 0);
      repeat (15) send_random();
    end
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_random();
  endtask

  task automatic test_output_holdoff();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_idle();
    hold_cycles = 3000;
    repeat (30) send_random();
  endtask

  // distance word checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_out++;
      if (distance_q.size() == 0) begin
        report_mismatch("unexpected distance word", distance_m_o, -1);
      end else begin
        if (distance_m_o !== distance_q[0])
          report_mismatch("distance_m", distance_m_o, distance_q[0]);
        void'(distance_q.pop_front());
      end
    end
  end

  // receiver stall and long hold-off count
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    kinv = gain_inv();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_radius_settings();
    test_random_phase(0, 0, 450);
    test_random_phase(58, 0, 450);
    test_random_phase(0, 58, 450);
    test_random_phase(12, 12, 450);
    test_output_holdoff();
    recv_stall_pct = 0;
    wait_idle();
    $display("run: %0d positions sent, %0d distance words checked, %0d mismatches",
             words_in, words_out, errors);
    $display("covered: field extremes, longitude wrap, poles, six radius settings, idle mixes");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
